// ----- hw/rtl/ltlg_pkg.sv -----
package ltlg_pkg;

  localparam int NUM_LEVELS = 5;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 24;
  localparam int ACC_W     = 25;
  localparam int LEVEL_W   = 3;
  localparam int LOAD_W    = 7;
  localparam int POLL_W    = 20;
  localparam int TH_W      = 7;
  localparam int TH_FIELDS = 5;
  localparam int TBL_W     = TH_W * TH_FIELDS;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 3;
  localparam int NUM_W     = ACC_W + LOAD_W;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FULL_WAKE  = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_TABLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_TABLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FASTEST       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOWEST       = 3'd4;

  // reset values
  localparam logic [POLL_W-1:0]  POLL_RESET    = 20'd100000;
  localparam logic [TBL_W-1:0]   UP_RESET      = {7'd0, 7'd40, 7'd55, 7'd75, 7'd127};
  localparam logic [TBL_W-1:0]   DOWN_RESET    = {7'd0, 7'd0, 7'd30, 7'd50, 7'd65};
  localparam logic [LEVEL_W-1:0] FASTEST_RESET = 3'd0;
  localparam logic [LEVEL_W-1:0] SLOWEST_RESET = 3'd4;

  localparam logic [LOAD_W-1:0] DIV_LAST_BIT = LOAD_W[LOAD_W-1:0] - 7'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] elapsed_time;
    logic [TIME_W-1:0] busy_us;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] power_level;
    logic               level_changed;
    logic               load_evaluated;
    logic [LOAD_W-1:0]  load_percent;
  } out_item_t;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_ACC,
    UOP_CHK,
    UOP_MUL,
    UOP_DIV,
    UOP_THR,
    UOP_STEP,
    UOP_EMIT
  } uop_e_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NO_ACCEPT,
    JC_NO_EVAL,
    JC_CNT_NZ,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    uop_e_t          op;
    jcond_t          cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] ADDR_WAIT = 3'd0;
  localparam logic [PC_W-1:0] ADDR_ACC  = 3'd1;
  localparam logic [PC_W-1:0] ADDR_CHK  = 3'd2;
  localparam logic [PC_W-1:0] ADDR_MUL  = 3'd3;
  localparam logic [PC_W-1:0] ADDR_DIV  = 3'd4;
  localparam logic [PC_W-1:0] ADDR_THR  = 3'd5;
  localparam logic [PC_W-1:0] ADDR_STEP = 3'd6;
  localparam logic [PC_W-1:0] ADDR_EMIT = 3'd7;

  // jump to target when the condition holds, else fall through (wraps to wait)
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    begin
      w = '{op: UOP_WAIT, cond: JC_NO_ACCEPT, target: ADDR_WAIT};
      case (addr)
        ADDR_WAIT: w = '{op: UOP_WAIT, cond: JC_NO_ACCEPT, target: ADDR_WAIT};
        ADDR_ACC:  w = '{op: UOP_ACC,  cond: JC_NEVER,     target: ADDR_WAIT};
        ADDR_CHK:  w = '{op: UOP_CHK,  cond: JC_NO_EVAL,   target: ADDR_EMIT};
        ADDR_MUL:  w = '{op: UOP_MUL,  cond: JC_NEVER,     target: ADDR_WAIT};
        ADDR_DIV:  w = '{op: UOP_DIV,  cond: JC_CNT_NZ,    target: ADDR_DIV};
        ADDR_THR:  w = '{op: UOP_THR,  cond: JC_NEVER,     target: ADDR_WAIT};
        ADDR_STEP: w = '{op: UOP_STEP, cond: JC_NEVER,     target: ADDR_WAIT};
        ADDR_EMIT: w = '{op: UOP_EMIT, cond: JC_OUT_BUSY,  target: ADDR_EMIT};
        default:   w = '{op: UOP_WAIT, cond: JC_NO_ACCEPT, target: ADDR_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

// ----- hw/rtl/load_threshold_level_governor_top.sv -----
// channel | direction | handshake               | payload
// in_     | input     | in_valid / in_stall     | ltlg_pkg::in_item_t (cmd, elapsed, busy)
// out_    | output    | out_valid / out_stall   | ltlg_pkg::out_item_t
// cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one transaction at a time, stepped by an 8-word microcode table
// evaluating load sample: accept, accumulate, check, multiply, a bit-serial restoring
// divide, threshold compare, level step, emit; other items skip from check to emit
// the next transaction is taken while the previous result waits in the output register
// rst_n is synchronous: accumulators and level cleared, registers back to defaults
// out_stall holds the result and the sequencer at its emit step; cfg_ready is always high
module load_threshold_level_governor_top #(
  parameter int NUM_LEVELS = ltlg_pkg::NUM_LEVELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ltlg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ltlg_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ltlg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ltlg_pkg::TBL_W-1:0]          cfg_data
);

  localparam logic [ltlg_pkg::LEVEL_W-1:0] TOP_LEVEL = ltlg_pkg::LEVEL_W'(NUM_LEVELS - 1);

  // configuration
  logic [ltlg_pkg::POLL_W-1:0]  poll_r;
  logic [ltlg_pkg::TBL_W-1:0]   up_tbl_r;
  logic [ltlg_pkg::TBL_W-1:0]   dn_tbl_r;
  logic [ltlg_pkg::LEVEL_W-1:0] fast_r;
  logic [ltlg_pkg::LEVEL_W-1:0] slow_r;

  // state and control
  logic [ltlg_pkg::PC_W-1:0]    pc_r;
  logic [ltlg_pkg::PC_W-1:0]    pc_nxt;
  logic [ltlg_pkg::ACC_W-1:0]   acc_e_r;
  logic [ltlg_pkg::ACC_W-1:0]   acc_b_r;
  logic [ltlg_pkg::LEVEL_W-1:0] lvl_r;
  logic                         out_valid_r;

  // datapath
  ltlg_pkg::in_item_t           item_r;
  logic [ltlg_pkg::ACC_W-1:0]   e_r;
  logic [ltlg_pkg::ACC_W-1:0]   b_r;
  logic                         smp_r;
  logic                         eval_r;
  logic                         chg_r;
  logic                         down_r;
  logic                         up_r;
  logic [ltlg_pkg::NUM_W-1:0]   num_r;
  logic [ltlg_pkg::NUM_W-1:0]   div_r;
  logic [ltlg_pkg::LOAD_W-1:0]  q_r;
  logic [ltlg_pkg::LOAD_W-1:0]  cnt_r;
  ltlg_pkg::out_item_t          out_r;

  ltlg_pkg::ucode_t             uw;
  logic                         in_acc;
  logic                         out_free;
  logic                         cond_hit;
  logic                         is_sample;
  logic                         eval_now;
  logic [ltlg_pkg::ACC_W:0]     sum_e;
  logic [ltlg_pkg::ACC_W:0]     sum_b;
  logic [ltlg_pkg::ACC_W-1:0]   sat_e;
  logic [ltlg_pkg::ACC_W-1:0]   sat_b;
  logic [ltlg_pkg::ACC_W-1:0]   b_clip;
  logic [ltlg_pkg::NUM_W-1:0]   num_mul;
  logic [ltlg_pkg::NUM_W:0]     trial;
  logic [ltlg_pkg::TH_W-1:0]    th_up;
  logic [ltlg_pkg::TH_W-1:0]    th_dn;
  logic [ltlg_pkg::LEVEL_W-1:0] hi_lvl;
  logic [ltlg_pkg::LEVEL_W-1:0] lo_cap;
  logic [ltlg_pkg::LEVEL_W-1:0] lo_lvl;
  logic [ltlg_pkg::LEVEL_W:0]   want;
  logic [ltlg_pkg::LEVEL_W-1:0] new_lvl;

  function automatic logic [ltlg_pkg::TH_W-1:0] th_field(
    input logic [ltlg_pkg::TBL_W-1:0]   tbl,
    input logic [ltlg_pkg::LEVEL_W-1:0] lvl
  );
    logic [ltlg_pkg::TBL_W-1:0] sh;
    begin
      sh = tbl >> (ltlg_pkg::TH_W * int'(lvl));
      if (int'(lvl) >= ltlg_pkg::TH_FIELDS) begin
        return '0;
      end
      return sh[ltlg_pkg::TH_W-1:0];
    end
  endfunction

  assign uw        = ltlg_pkg::ucode_rom(pc_r);
  assign in_stall  = (uw.op != ltlg_pkg::UOP_WAIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // accumulate with saturation
  assign is_sample = (item_r.cmd == ltlg_pkg::CMD_SAMPLE) && (item_r.elapsed_time != '0);
  assign sum_e = {1'b0, acc_e_r} + (ltlg_pkg::ACC_W + 1)'(item_r.elapsed_time);
  assign sum_b = {1'b0, acc_b_r} + (ltlg_pkg::ACC_W + 1)'(item_r.busy_us);
  assign sat_e = sum_e[ltlg_pkg::ACC_W] ? ltlg_pkg::ACC_MAX : sum_e[ltlg_pkg::ACC_W-1:0];
  assign sat_b = sum_b[ltlg_pkg::ACC_W] ? ltlg_pkg::ACC_MAX : sum_b[ltlg_pkg::ACC_W-1:0];

  assign eval_now = smp_r && (e_r > ltlg_pkg::ACC_W'(poll_r));

  // 100 * min(busy, elapsed) as shift-add
  assign b_clip  = (b_r > e_r) ? e_r : b_r;
  assign num_mul = (ltlg_pkg::NUM_W'(b_clip) << 6) + (ltlg_pkg::NUM_W'(b_clip) << 5)
                 + (ltlg_pkg::NUM_W'(b_clip) << 2);

  assign trial = {1'b0, num_r} - {1'b0, div_r};

  assign th_up = th_field(up_tbl_r, lvl_r);
  assign th_dn = th_field(dn_tbl_r, lvl_r);

  // allowed range, then one level step, clamped into it
  assign hi_lvl = (slow_r > TOP_LEVEL) ? TOP_LEVEL : slow_r;
  assign lo_cap = (fast_r > TOP_LEVEL) ? TOP_LEVEL : fast_r;
  assign lo_lvl = (lo_cap > hi_lvl) ? hi_lvl : lo_cap;

  always_comb begin
    if (down_r) begin
      want = {1'b0, lvl_r} + (ltlg_pkg::LEVEL_W + 1)'(1);
    end else if (lvl_r == '0) begin
      want = '0;
    end else begin
      want = {1'b0, lvl_r} - (ltlg_pkg::LEVEL_W + 1)'(1);
    end
    if (want > {1'b0, hi_lvl}) begin
      new_lvl = hi_lvl;
    end else if (want < {1'b0, lo_lvl}) begin
      new_lvl = lo_lvl;
    end else begin
      new_lvl = want[ltlg_pkg::LEVEL_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    case (uw.cond)
      ltlg_pkg::JC_NEVER:     cond_hit = 1'b0;
      ltlg_pkg::JC_NO_ACCEPT: cond_hit = !in_acc;
      ltlg_pkg::JC_NO_EVAL:   cond_hit = !eval_now;
      ltlg_pkg::JC_CNT_NZ:    cond_hit = (cnt_r != '0);
      ltlg_pkg::JC_OUT_BUSY:  cond_hit = !out_free;
      default:                cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.target : pc_r + ltlg_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ltlg_pkg::ADDR_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r   <= ltlg_pkg::POLL_RESET;
      up_tbl_r <= ltlg_pkg::UP_RESET;
      dn_tbl_r <= ltlg_pkg::DOWN_RESET;
      fast_r   <= ltlg_pkg::FASTEST_RESET;
      slow_r   <= ltlg_pkg::SLOWEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ltlg_pkg::REG_POLL_INTERVAL: poll_r   <= cfg_data[ltlg_pkg::POLL_W-1:0];
        ltlg_pkg::REG_UP_TABLE:      up_tbl_r <= cfg_data;
        ltlg_pkg::REG_DOWN_TABLE:    dn_tbl_r <= cfg_data;
        ltlg_pkg::REG_FASTEST:       fast_r   <= cfg_data[ltlg_pkg::LEVEL_W-1:0];
        ltlg_pkg::REG_SLOWEST:       slow_r   <= cfg_data[ltlg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // governor state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_e_r     <= '0;
      acc_b_r     <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if ((uw.op == ltlg_pkg::UOP_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (uw.op)
        ltlg_pkg::UOP_ACC: begin
          if (item_r.cmd == ltlg_pkg::CMD_FULL_WAKE) begin
            acc_e_r <= '0;
            acc_b_r <= '0;
          end else if (is_sample) begin
            acc_e_r <= sat_e;
            acc_b_r <= sat_b;
          end
        end
        ltlg_pkg::UOP_MUL: begin
          acc_e_r <= '0;
          acc_b_r <= '0;
        end
        ltlg_pkg::UOP_STEP: begin
          if (down_r || up_r) begin
            lvl_r <= new_lvl;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (uw.op)
      ltlg_pkg::UOP_WAIT: begin
        if (in_acc) begin
          item_r <= in_data;
          eval_r <= 1'b0;
          chg_r  <= 1'b0;
        end
      end
      ltlg_pkg::UOP_ACC: begin
        e_r   <= sat_e;
        b_r   <= sat_b;
        smp_r <= is_sample;
      end
      ltlg_pkg::UOP_CHK: begin
        eval_r <= eval_now;
      end
      ltlg_pkg::UOP_MUL: begin
        num_r <= num_mul;
        div_r <= ltlg_pkg::NUM_W'(e_r) << (ltlg_pkg::LOAD_W - 1);
        q_r   <= '0;
        cnt_r <= ltlg_pkg::DIV_LAST_BIT;
      end
      ltlg_pkg::UOP_DIV: begin
        // restoring divide, one quotient bit per step
        if (!trial[ltlg_pkg::NUM_W]) begin
          num_r <= trial[ltlg_pkg::NUM_W-1:0];
        end
        q_r   <= {q_r[ltlg_pkg::LOAD_W-2:0], !trial[ltlg_pkg::NUM_W]};
        div_r <= div_r >> 1;
        cnt_r <= cnt_r - ltlg_pkg::LOAD_W'(1);
      end
      ltlg_pkg::UOP_THR: begin
        down_r <= (q_r < th_dn);
        up_r   <= (q_r > th_up);
      end
      ltlg_pkg::UOP_STEP: begin
        chg_r <= (down_r || up_r) && (new_lvl != lvl_r);
      end
      ltlg_pkg::UOP_EMIT: begin
        if (out_free) begin
          out_r.power_level    <= lvl_r;
          out_r.level_changed  <= chg_r;
          out_r.load_evaluated <= eval_r;
          out_r.load_percent   <= eval_r ? q_r : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/ltlg_chk.sv -----
module ltlg_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input ltlg_pkg::out_item_t            out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // one transaction in flight: a taken item blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken back to back");

  a_change_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.level_changed |-> out_data.load_evaluated)
    else $error("level moved without a load evaluation");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.load_percent <= 7'd100)
      && (out_data.load_evaluated || (out_data.load_percent == 7'd0)))
    else $error("load percent out of range");

endmodule

bind load_threshold_level_governor_top ltlg_chk u_ltlg_chk (.*);
